FILE: rtl/core/bld_pkg.sv
// Shared types and codes for the bounded list deque core.
// No dependencies; every other file but bld_ram imports this package.
package bld_pkg;

	// Default sizing handed to the top level
	localparam int CAPACITY_DEF    = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed payload widths
	localparam int OPCODE_W  = 3;
	localparam int OPERAND_W = 32;
	localparam int STATUS_W  = 2;
	localparam int LENGTH_W  = 5;

	// Operation codes
	localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_DELETE     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_POP_WAIT,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

	// One response
	typedef struct packed {
		logic [STATUS_W-1:0]         status;
		logic signed [OPERAND_W-1:0] removed_value;
		logic                        found;
		logic [LENGTH_W-1:0]         length;
	} res_t;

endpackage

FILE: rtl/core/bld_if.sv
// Request and response channel interfaces of the list deque core.
// Depends on bld_pkg for the payload widths.
interface bld_in_if;
	import bld_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [OPCODE_W-1:0]         opcode;
	logic signed [OPERAND_W-1:0] operand;

	modport source (output valid, output opcode, output operand, input ready);
	modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface bld_out_if;
	import bld_pkg::*;
	logic                        valid;
	logic                        ready;
	logic [STATUS_W-1:0]         status;
	logic signed [OPERAND_W-1:0] removed_value;
	logic                        found;
	logic [LENGTH_W-1:0]         length;

	modport source (output valid, output status, output removed_value, output found,
		output length, input ready);
	modport sink   (input valid, input status, input removed_value, input found,
		input length, output ready);
endinterface

FILE: rtl/core/bld_ram.sv
// Element store: one write port, one read port with registered read data.
// No package dependency.
module bld_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/bld_ctrl.sv
// Sequencer for the list deque: circular head pointer, count and the walk
// over the element store. Depends on bld_pkg; drives a bld_ram port pair.
module bld_ctrl #(
	parameter int CAPACITY    = bld_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bld_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  logic [bld_pkg::OPCODE_W-1:0]        opcode,
	input  logic signed [bld_pkg::OPERAND_W-1:0] operand,
	output logic                                res_valid,
	input  logic                                res_take,
	output bld_pkg::res_t                       res,
	output logic                                mem_wr_en,
	output logic [$clog2(CAPACITY)-1:0]         mem_wr_addr,
	output logic [VALUE_WIDTH-1:0]              mem_wr_data,
	output logic                                mem_rd_en,
	output logic [$clog2(CAPACITY)-1:0]         mem_rd_addr,
	input  logic [VALUE_WIDTH-1:0]              mem_rd_data
);
	import bld_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	state_t                 state_q, state_d;
	logic [OPCODE_W-1:0]    op_q;
	logic [VALUE_WIDTH-1:0] key_q;
	logic [AW-1:0]          head_q, head_d, head_dec;
	logic [CW-1:0]          count_q, count_d;
	logic [AW:0]            idx_q, idx_d;
	logic [AW:0]            count_w;
	logic [AW:0]            rd_off, wr_off;
	logic                   wr_front;
	logic                   full, empty;
	res_t                   res_q, res_d;

	// Add an offset to a store address, wrapping once at the capacity
	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW:0] off);
		logic [AW:0] s;
		s = {1'b0, base} + off;
		if (s >= (AW+1)'(CAPACITY)) begin
			s = s - (AW+1)'(CAPACITY);
		end
		return s[AW-1:0];
	endfunction

	assign count_w  = (AW+1)'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);

	assign cmd_ready   = (state_q == ST_IDLE);
	assign res         = res_q;
	assign mem_rd_addr = wrap_add(head_q, rd_off);
	assign mem_wr_addr = wr_front ? head_dec : wrap_add(head_q, wr_off);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// Payload registers: latch the request, walk index and pending response
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			op_q  <= opcode;
			key_q <= VALUE_WIDTH'(operand);
		end
		idx_q <= idx_d;
		res_q <= res_d;
	end

	// Next state, store accesses and response build
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		count_d     = count_q;
		idx_d       = idx_q;
		res_d       = res_q;
		rd_off      = '0;
		wr_off      = '0;
		wr_front    = 1'b0;
		mem_rd_en   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_data = key_q;
		res_valid   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_DISPATCH;
				end
			end

			ST_DISPATCH: begin
				res_d.status        = STATUS_OK;
				res_d.removed_value = '0;
				res_d.found         = 1'b0;
				res_d.length        = LENGTH_W'(count_q);
				state_d             = ST_DONE;
				unique case (op_q)
					OP_PUSH_FRONT: begin
						if (full) begin
							res_d.status = STATUS_FULL;
						end else begin
							mem_wr_en    = 1'b1;
							wr_front     = 1'b1;
							head_d       = head_dec;
							count_d      = count_q + CW'(1);
							res_d.length = LENGTH_W'(count_q + CW'(1));
						end
					end
					OP_PUSH_BACK: begin
						if (full) begin
							res_d.status = STATUS_FULL;
						end else begin
							mem_wr_en    = 1'b1;
							wr_off       = count_w;
							count_d      = count_q + CW'(1);
							res_d.length = LENGTH_W'(count_q + CW'(1));
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (empty) begin
							res_d.status = STATUS_EMPTY;
						end else begin
							mem_rd_en = 1'b1;
							rd_off    = (op_q == OP_POP_FRONT) ? '0 : count_w - (AW+1)'(1);
							state_d   = ST_POP_WAIT;
						end
					end
					OP_DELETE, OP_SEARCH: begin
						if (empty) begin
							res_d.status = STATUS_NOT_FOUND;
						end else begin
							mem_rd_en = 1'b1;
							rd_off    = '0;
							idx_d     = '0;
							state_d   = ST_SCAN;
						end
					end
					default: begin
					end
				endcase
			end

			// Take the popped value and shrink the list
			ST_POP_WAIT: begin
				res_d.removed_value = signed'(32'(mem_rd_data));
				count_d             = count_q - CW'(1);
				res_d.length        = LENGTH_W'(count_q - CW'(1));
				if (op_q == OP_POP_FRONT) begin
					head_d = wrap_add(head_q, (AW+1)'(1));
				end
				state_d = ST_DONE;
			end

			// Compare one element a cycle, prefetch the next
			ST_SCAN: begin
				mem_rd_en = 1'b1;
				rd_off    = idx_q + (AW+1)'(1);
				if (mem_rd_data == key_q) begin
					res_d.found = 1'b1;
					if (op_q == OP_DELETE) begin
						res_d.removed_value = signed'(32'(mem_rd_data));
						res_d.length        = LENGTH_W'(count_q - CW'(1));
						if (idx_q + (AW+1)'(1) == count_w) begin
							count_d = count_q - CW'(1);
							state_d = ST_DONE;
						end else begin
							state_d = ST_SHIFT;
						end
					end else begin
						state_d = ST_DONE;
					end
				end else if (idx_q + (AW+1)'(1) == count_w) begin
					res_d.status = STATUS_NOT_FOUND;
					state_d      = ST_DONE;
				end else begin
					idx_d = idx_q + (AW+1)'(1);
				end
			end

			// Close the gap: move each later element down by one
			ST_SHIFT: begin
				mem_wr_en   = 1'b1;
				wr_off      = idx_q;
				mem_wr_data = mem_rd_data;
				mem_rd_en   = 1'b1;
				rd_off      = idx_q + (AW+1)'(2);
				if (idx_q + (AW+1)'(2) == count_w) begin
					count_d = count_q - CW'(1);
					state_d = ST_DONE;
				end else begin
					idx_d = idx_q + (AW+1)'(1);
				end
			end

			// Hold the response until the output register takes it
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/bounded_list_deque_with_delete_core.sv
// Top level of the bounded list deque with delete and search.
// Depends on bld_pkg, bld_if, bld_ram and bld_ctrl.
//
// Usage:
//   cmd carries one request (opcode, operand); rsp returns exactly one
//   response (status, removed_value, found, length) per request, in order.
//   Both channels transfer when valid and ready are high at a clock edge.
// Sequence (one request at a time, single read port walk): a push goes
//   from dispatch straight to the response; a pop waits for the read
//   data first; search and delete scan up to the match, and delete then
//   shifts the later elements down by one. The sequencer returns to idle
//   before the next request is taken.
//   The next request may be taken while the previous response still sits
//   in the output register.
// Reset clears the count and head pointer at once; the element store is
//   not cleared and needs no sweep. A stalled receiver holds the response
//   in place; a second finished response waits in the sequencer and no
//   further request is taken until the output register drains.
module bounded_list_deque_with_delete_core #(
	parameter int CAPACITY    = bld_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = bld_pkg::VALUE_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	bld_in_if.sink           cmd,
	bld_out_if.source        rsp
);
	import bld_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	logic                   wr_en, rd_en;
	logic [AW-1:0]          wr_addr, rd_addr;
	logic [VALUE_WIDTH-1:0] wr_data, rd_data;
	logic                   res_valid, res_take;
	res_t                   res;
	res_t                   out_q;
	logic                   out_valid_q;

	bld_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	bld_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd.valid),
		.cmd_ready   (cmd.ready),
		.opcode      (cmd.opcode),
		.operand     (cmd.operand),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res),
		.mem_wr_en   (wr_en),
		.mem_wr_addr (wr_addr),
		.mem_wr_data (wr_data),
		.mem_rd_en   (rd_en),
		.mem_rd_addr (rd_addr),
		.mem_rd_data (rd_data)
	);

	// Load the output register when it is empty or being drained
	assign res_take = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	// Drive the response channel
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.removed_value = out_q.removed_value;
	assign rsp.found         = out_q.found;
	assign rsp.length        = out_q.length;

endmodule
